[src/tlsg_pkg.sv]
// tlsg_pkg: shared constants, command codes and the per-axis move type
// for the two-axis line step generator
// no dependencies
`default_nettype none

package tlsg_pkg;

   localparam int POS_BITS  = 24;
   localparam int IN_BITS   = 24;
   localparam int MAG_BITS  = (POS_BITS > IN_BITS) ? POS_BITS : IN_BITS;
   localparam int DIFF_BITS = MAG_BITS + 2;

   typedef enum logic [1:0] {
      FUNC_REL  = 2'd0,
      FUNC_ABS  = 2'd1,
      FUNC_TICK = 2'd2,
      FUNC_ZERO = 2'd3
   } func_type;

   typedef struct packed {
      logic [POS_BITS-1:0] pos;
      logic [MAG_BITS-1:0] mag;
      logic                neg;
   } axis_move_type;

endpackage

`default_nettype wire

[src/tlsg_axis_calc.sv]
// tlsg_axis_calc: new position, step count and sign for one axis of a move
// relative delta or absolute target, wrapping position arithmetic
// depends on tlsg_pkg
`default_nettype none

module tlsg_axis_calc (
   input  wire logic                                 absolute,
   input  wire logic signed [tlsg_pkg::IN_BITS-1:0]  delta,
   input  wire logic [tlsg_pkg::POS_BITS-1:0]        pos,
   output tlsg_pkg::axis_move_type                   move
);
   import tlsg_pkg::*;

   logic signed [MAG_BITS-1:0] delta_ext;
   logic [POS_BITS-1:0]        delta_pos;
   logic [POS_BITS-1:0]        diff;
   logic [POS_BITS-1:0]        abs_mag;
   logic [IN_BITS-1:0]         rel_mag;
   logic                       rel_neg;

   always_comb begin
      delta_ext = MAG_BITS'(delta);
      delta_pos = delta_ext[POS_BITS-1:0];
      rel_neg   = delta[IN_BITS-1];
      rel_mag   = rel_neg ? (IN_BITS'(0) - delta) : delta;
      diff      = delta_pos - pos;
      abs_mag   = diff[POS_BITS-1] ? (POS_BITS'(0) - diff) : diff;
      if (absolute) begin
         move.pos = delta_pos;
         move.mag = MAG_BITS'(abs_mag);
         move.neg = diff[POS_BITS-1];
      end else begin
         move.pos = pos + delta_pos;
         move.mag = MAG_BITS'(rel_mag);
         move.neg = rel_neg;
      end
   end

endmodule

`default_nettype wire

[src/two_axis_line_step_generator.sv]
// two_axis_line_step_generator: top level, move state and integer line stepping
// one input register, one pass of logic, one result register
// depends on tlsg_pkg and tlsg_axis_calc
//
// usage
//   req_* carries one item: func (relative move, absolute move, tick, zero
//   position), two signed deltas or targets and the two limit sensors.
//   rsp_* returns exactly one result item for every request item, in order:
//   step pulses, direction levels, busy, done, limit error and rejected.
//   a move command starts a line; each following tick item is one pulse
//   period and issues at most one step per axis; the tick after the last
//   step reports move_done. commands sent during a move are rejected.
// flow and throughput
//   items pass from the input register to the result register on rsp_*;
//   one item per cycle is sustained while rsp_stall is low; longest path:
//   a move command's target difference, negation and magnitude compare.
// reset and stall
//   reset clears position, directions and move state; no result is pending.
//   while rsp_stall holds a result, the input register keeps one more item
//   and req_stall rises only once that register is also full.
`default_nettype none

module two_axis_line_step_generator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_func,
   input  wire logic signed [tlsg_pkg::IN_BITS-1:0]  req_delta_x,
   input  wire logic signed [tlsg_pkg::IN_BITS-1:0]  req_delta_y,
   input  wire logic                                 req_sensor_x,
   input  wire logic                                 req_sensor_y,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_step_x,
   output logic                                      rsp_step_y,
   output logic                                      rsp_dir_x,
   output logic                                      rsp_dir_y,
   output logic                                      rsp_busy_res,
   output logic                                      rsp_move_done,
   output logic                                      rsp_limit_error,
   output logic                                      rsp_rejected
);
   import tlsg_pkg::*;

   // input register
   logic                       in_valid_ff,  in_valid_in;
   func_type                   in_func_ff;
   logic signed [IN_BITS-1:0]  in_dx_ff, in_dy_ff;
   logic                       in_sens_ff;

   // move state
   logic [POS_BITS-1:0]         pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic                        dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic [MAG_BITS-1:0]         count_x_ff, count_x_in, count_y_ff, count_y_in;
   logic [MAG_BITS-1:0]         longest_ff, longest_in;
   logic [MAG_BITS-1:0]         rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic signed [DIFF_BITS-1:0] err_x_ff, err_x_in, err_y_ff, err_y_in;
   logic                        moving_ff, moving_in;
   logic                        armed_ff, armed_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic done_ff, done_in, limit_ff, limit_in, rej_ff, rej_in;

   logic                        advance;
   logic                        take_req;
   axis_move_type               move_x, move_y;
   logic                        fire_x, fire_y;
   logic signed [DIFF_BITS-1:0] count_x_s, count_y_s, longest_s;

   tlsg_axis_calc u_calc_x (
      .absolute (in_func_ff == FUNC_ABS),
      .delta    (in_dx_ff),
      .pos      (pos_x_ff),
      .move     (move_x)
   );

   tlsg_axis_calc u_calc_y (
      .absolute (in_func_ff == FUNC_ABS),
      .delta    (in_dy_ff),
      .pos      (pos_y_ff),
      .move     (move_y)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign take_req  = req_valid && !req_stall;

   assign count_x_s = $signed({2'b00, count_x_ff});
   assign count_y_s = $signed({2'b00, count_y_ff});
   assign longest_s = $signed({2'b00, longest_ff});

   always_comb begin
      in_valid_in = take_req ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      dir_x_in   = dir_x_ff;
      dir_y_in   = dir_y_ff;
      count_x_in = count_x_ff;
      count_y_in = count_y_ff;
      longest_in = longest_ff;
      rem_x_in   = rem_x_ff;
      rem_y_in   = rem_y_ff;
      err_x_in   = err_x_ff;
      err_y_in   = err_y_ff;
      moving_in  = moving_ff;
      armed_in   = armed_ff;
      step_x_in  = 1'b0;
      step_y_in  = 1'b0;
      done_in    = 1'b0;
      limit_in   = 1'b0;
      rej_in     = 1'b0;

      fire_x = (rem_x_ff != '0) && (err_x_ff > 0);
      fire_y = (rem_y_ff != '0) && (err_y_ff > 0);

      if (in_func_ff != FUNC_TICK) begin
         if (moving_ff) begin
            rej_in = 1'b1;
         end else if (in_func_ff == FUNC_ZERO) begin
            pos_x_in = '0;
            pos_y_in = '0;
         end else begin
            pos_x_in = move_x.pos;
            pos_y_in = move_y.pos;
            if (move_x.mag != '0) begin
               dir_x_in = move_x.neg;
            end
            if (move_y.mag != '0) begin
               dir_y_in = move_y.neg;
            end
            count_x_in = move_x.mag;
            count_y_in = move_y.mag;
            longest_in = (move_x.mag > move_y.mag) ? move_x.mag : move_y.mag;
            rem_x_in   = move_x.mag;
            rem_y_in   = move_y.mag;
            err_x_in   = '0;
            err_y_in   = '0;
            armed_in   = move_x.neg || move_y.neg;
            moving_in  = (move_x.mag != '0) || (move_y.mag != '0);
         end
      end else if (moving_ff) begin
         if (armed_ff && in_sens_ff) begin
            limit_in  = 1'b1;
            moving_in = 1'b0;
         end else if ((rem_x_ff == '0) && (rem_y_ff == '0)) begin
            done_in   = 1'b1;
            moving_in = 1'b0;
         end else begin
            step_x_in = fire_x;
            step_y_in = fire_y;
            if (fire_x) begin
               rem_x_in = rem_x_ff - MAG_BITS'(1);
               err_x_in = err_x_ff + count_x_s - longest_s;
            end else begin
               err_x_in = err_x_ff + count_x_s;
            end
            if (fire_y) begin
               rem_y_in = rem_y_ff - MAG_BITS'(1);
               err_y_in = err_y_ff + count_y_s - longest_s;
            end else begin
               err_y_in = err_y_ff + count_y_s;
            end
         end
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_func_ff <= func_type'(req_func);
         in_dx_ff   <= req_delta_x;
         in_dy_ff   <= req_delta_y;
         in_sens_ff <= req_sensor_x || req_sensor_y;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
         done_ff   <= done_in;
         limit_ff  <= limit_in;
         rej_ff    <= rej_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         dir_x_ff     <= 1'b0;
         dir_y_ff     <= 1'b0;
         count_x_ff   <= '0;
         count_y_ff   <= '0;
         longest_ff   <= '0;
         rem_x_ff     <= '0;
         rem_y_ff     <= '0;
         err_x_ff     <= '0;
         err_y_ff     <= '0;
         moving_ff    <= 1'b0;
         armed_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            pos_x_ff   <= pos_x_in;
            pos_y_ff   <= pos_y_in;
            dir_x_ff   <= dir_x_in;
            dir_y_ff   <= dir_y_in;
            count_x_ff <= count_x_in;
            count_y_ff <= count_y_in;
            longest_ff <= longest_in;
            rem_x_ff   <= rem_x_in;
            rem_y_ff   <= rem_y_in;
            err_x_ff   <= err_x_in;
            err_y_ff   <= err_y_in;
            moving_ff  <= moving_in;
            armed_ff   <= armed_in;
         end
      end
   end

   // direction and busy are taken from the state the item left behind
   logic dir_x_out_ff, dir_y_out_ff, busy_out_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         dir_x_out_ff <= dir_x_in;
         dir_y_out_ff <= dir_y_in;
         busy_out_ff  <= moving_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_step_x      = step_x_ff;
   assign rsp_step_y      = step_y_ff;
   assign rsp_dir_x       = dir_x_out_ff;
   assign rsp_dir_y       = dir_y_out_ff;
   assign rsp_busy_res    = busy_out_ff;
   assign rsp_move_done   = done_ff;
   assign rsp_limit_error = limit_ff;
   assign rsp_rejected    = rej_ff;

`ifndef SYNTHESIS
   a_rem_bounded : assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (rem_x_ff <= count_x_ff) && (rem_y_ff <= count_y_ff))
      else $error("remaining steps exceed step count");

   a_longest_max : assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (count_x_ff <= longest_ff) && (count_y_ff <= longest_ff)
                    && ((longest_ff == count_x_ff) || (longest_ff == count_y_ff)))
      else $error("longest is not the larger step count");

   a_err_window : assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (err_x_ff <= longest_s) && (err_x_ff > -longest_s)
                    && (err_y_ff <= longest_s) && (err_y_ff > -longest_s))
      else $error("line error term out of range");

   a_end_exclusive : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_move_done || rsp_limit_error)) |->
         !rsp_step_x && !rsp_step_y && !rsp_busy_res && !rsp_rejected)
      else $error("move end item carries steps or busy");

   a_done_after_last : assert property (@(posedge clock) disable iff (reset)
      (advance && done_in) |-> (rem_x_ff == '0) && (rem_y_ff == '0) && moving_ff)
      else $error("move done with steps outstanding");
`endif

endmodule

`default_nettype wire
